// File: hw/rtl/supertoroid_point_eval_macros.svh
// Assertion shorthands for the supertoroid point pipeline.
// Each expects i_clk and i_rst_n in scope.
`ifndef SUPERTOROID_POINT_EVAL_MACROS_SVH
`define SUPERTOROID_POINT_EVAL_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define STPE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/stpe_pkg.sv
package stpe_pkg;

    localparam logic [31:0] ONE_Q30     = 32'd1073741824;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int CS_W     = 18;
    localparam int LANE_LAT = 73;

    typedef enum logic [2:0] {
        CFG_RING     = 3'd0,
        CFG_TUBE     = 3'd1,
        CFG_SCALE_X  = 3'd2,
        CFG_SCALE_Y  = 3'd3,
        CFG_SCALE_Z  = 3'd4,
        CFG_EXP_RING = 3'd5,
        CFG_EXP_TUBE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [30:0] x;
        logic        odd;
        logic        neg;
    } t_lane_in;

endpackage

// File: hw/rtl/stpe_in_if.sv
interface stpe_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle_u;
    logic [15:0] angle_v;

    modport source (output valid, output angle_u, output angle_v, input ready);
    modport sink   (input valid, input angle_u, input angle_v, output ready);
endinterface

// File: hw/rtl/stpe_out_if.sv
interface stpe_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic        saturated;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output saturated, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input saturated, output ready);
endinterface

// File: hw/rtl/stpe_lane.sv
module stpe_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  stpe_pkg::t_lane_in             i_in,
    input  logic [15:0]                    i_exp,
    output logic signed [stpe_pkg::CS_W-1:0] o_cs
);

    typedef struct packed {
        logic [30:0]        x;
        logic [31:0]        term;
        logic [31:0]        q0;
        logic signed [33:0] sum;
        logic               odd;
        logic               neg;
    } t_tay;

    typedef struct packed {
        logic [30:0] m;
        logic [19:0] frac;
        logic [4:0]  p;
        logic        zero;
        logic        neg;
    } t_pw;

    typedef struct packed {
        logic [30:0] r;
        logic [19:0] hb;
        logic [8:0]  ip;
        logic        gz;
        logic        zero;
        logic        neg;
    } t_ex;

    typedef logic [20:0][31:0] t_roots;

    function automatic t_roots f_roots();
        t_roots      tab;
        logic [63:0] a;
        logic [63:0] res;
        logic [63:0] bt;
        int          k;
        int          i;
        tab[0] = 32'(2 * 64'(stpe_pkg::ONE_Q30));
        for (k = 1; k <= 20; k++) begin
            a   = 64'(tab[k-1]) << 30;
            res = '0;
            for (i = 0; i < 32; i++) begin
                bt = 64'd1 << (62 - 2 * i);
                if (a >= res + bt) begin
                    a   = a - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
            end
            tab[k] = res[31:0];
        end
        return tab;
    endfunction

    localparam t_roots ROOT = f_roots();

    localparam logic [7:0] DIV_S [7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
    localparam logic [7:0] DIV_C [7] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
    localparam logic [31:0] REC_S [7] = '{
        32'(64'h1_0000_0000 / 64'd6),   32'(64'h1_0000_0000 / 64'd20),
        32'(64'h1_0000_0000 / 64'd42),  32'(64'h1_0000_0000 / 64'd72),
        32'(64'h1_0000_0000 / 64'd110), 32'(64'h1_0000_0000 / 64'd156),
        32'(64'h1_0000_0000 / 64'd210)};
    localparam logic [31:0] REC_C [7] = '{
        32'(64'h1_0000_0000 / 64'd2),   32'(64'h1_0000_0000 / 64'd12),
        32'(64'h1_0000_0000 / 64'd30),  32'(64'h1_0000_0000 / 64'd56),
        32'(64'h1_0000_0000 / 64'd90),  32'(64'h1_0000_0000 / 64'd132),
        32'(64'h1_0000_0000 / 64'd182)};

    t_tay r_dv [0:7];
    t_tay r_m1 [0:6];
    t_tay r_m2 [0:6];
    t_tay r_rc [0:6];

    logic [16:0] r_mag;
    logic        r_mneg;

    t_pw r_pw [0:20];
    t_ex r_ex [0:20];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= '{x:    i_in.x,
                         term: i_in.odd ? 32'(i_in.x) : stpe_pkg::ONE_Q30,
                         q0:   '0,
                         sum:  i_in.odd ? $signed(34'(i_in.x))
                                        : $signed(34'(stpe_pkg::ONE_Q30)),
                         odd:  i_in.odd,
                         neg:  i_in.neg};
        end
    end

    for (genvar k = 0; k < 7; k++) begin : g_tay
        logic [62:0] w_p1;
        logic [62:0] w_p2;
        logic [63:0] w_pr;
        logic [31:0] w_m;
        logic [7:0]  w_d;
        logic [31:0] w_rem;
        logic [31:0] w_q;
        t_tay        n_m1;
        t_tay        n_m2;
        t_tay        n_rc;
        t_tay        n_dv;

        assign w_p1  = 63'(r_dv[k].term) * 63'(r_dv[k].x);
        assign w_p2  = 63'(r_m1[k].term) * 63'(r_m1[k].x);
        assign w_m   = r_m2[k].odd ? REC_S[k] : REC_C[k];
        assign w_pr  = 64'(r_m2[k].term) * 64'(w_m);
        assign w_d   = r_rc[k].odd ? DIV_S[k] : DIV_C[k];
        assign w_rem = r_rc[k].term - 32'(r_rc[k].q0 * 32'(w_d));
        assign w_q   = (w_rem >= 32'(w_d)) ? r_rc[k].q0 + 32'd1 : r_rc[k].q0;

        always_comb begin
            n_m1      = r_dv[k];
            n_m1.term = w_p1[61:30];
            n_m2      = r_m1[k];
            n_m2.term = w_p2[61:30];
            n_rc      = r_m2[k];
            n_rc.q0   = w_pr[63:32];
            n_dv      = r_rc[k];
            n_dv.term = w_q;
            if (k % 2 == 0) begin
                n_dv.sum = r_rc[k].sum - $signed(34'(w_q));
            end else begin
                n_dv.sum = r_rc[k].sum + $signed(34'(w_q));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m1[k]   <= n_m1;
                r_m2[k]   <= n_m2;
                r_rc[k]   <= n_rc;
                r_dv[k+1] <= n_dv;
            end
        end
    end

    logic [30:0] w_cl;
    logic [30:0] w_rnd;

    always_comb begin
        if (r_dv[7].sum < 0) begin
            w_cl = '0;
        end else if (r_dv[7].sum > $signed(34'(stpe_pkg::ONE_Q30))) begin
            w_cl = 31'(stpe_pkg::ONE_Q30);
        end else begin
            w_cl = r_dv[7].sum[30:0];
        end
        w_rnd = w_cl + 31'd8192;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= w_rnd[30:14];
            r_mneg <= r_dv[7].neg;
        end
    end

    logic [4:0] w_p;

    always_comb begin
        w_p = '0;
        for (int i = 0; i < 17; i++) begin
            if (r_mag[i]) begin
                w_p = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pw[0] <= '{m:    31'(r_mag) << (5'd30 - w_p),
                         frac: '0,
                         p:    w_p,
                         zero: (r_mag == '0),
                         neg:  r_mneg};
        end
    end

    for (genvar i = 0; i < 20; i++) begin : g_log
        logic [61:0] w_sq;
        t_pw         n_pw;

        assign w_sq = 62'(r_pw[i].m) * 62'(r_pw[i].m);

        always_comb begin
            n_pw = r_pw[i];
            if (w_sq[61]) begin
                n_pw.m          = w_sq[61:31];
                n_pw.frac[19-i] = 1'b1;
            end else begin
                n_pw.m = w_sq[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pw[i+1] <= n_pw;
            end
        end
    end

    logic [24:0] w_negl;
    logic [40:0] w_q41;
    logic [31:0] w_h;

    assign w_negl = (25'(5'd16 - r_pw[20].p) << 20) - 25'(r_pw[20].frac);
    assign w_q41  = 41'(w_negl) * 41'(i_exp);
    assign w_h    = ~w_q41[31:0] + 32'd1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex[0] <= '{r:    31'(stpe_pkg::ONE_Q30),
                         hb:   w_h[31:12],
                         ip:   w_q41[40:32],
                         gz:   (w_q41[31:0] == '0),
                         zero: r_pw[20].zero,
                         neg:  r_pw[20].neg};
        end
    end

    for (genvar i = 0; i < 20; i++) begin : g_exp
        logic [61:0] w_e;
        t_ex         n_ex;

        assign w_e = 62'(r_ex[i].r) * 62'(ROOT[i+1]);

        always_comb begin
            n_ex = r_ex[i];
            if (r_ex[i].hb[19-i]) begin
                n_ex.r = w_e[60:30];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ex[i+1] <= n_ex;
            end
        end
    end

    logic [5:0]  w_s;
    logic [63:0] w_sh;
    logic [16:0] w_pow;

    always_comb begin
        w_s  = 6'(r_ex[20].ip[4:0]) + 6'd15;
        w_sh = (64'(r_ex[20].r) + (64'd1 << (w_s - 6'd1))) >> w_s;
        if (r_ex[20].zero) begin
            w_pow = '0;
        end else if (i_exp == '0) begin
            w_pow = 17'h10000;
        end else if (r_ex[20].gz) begin
            w_pow = (r_ex[20].ip > 9'd16) ? '0 : (17'h10000 >> r_ex[20].ip[4:0]);
        end else if (r_ex[20].ip > 9'd25) begin
            w_pow = '0;
        end else begin
            w_pow = w_sh[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cs <= (r_ex[20].neg && (i_exp != '0)) ? -$signed(18'(w_pow)) : $signed(18'(w_pow));
        end
    end

endmodule

// File: hw/rtl/supertoroid_point_eval.sv
// Channel   Dir  Fields                                  Handshake
// i_ang     in   angle_u, angle_v                        valid / ready
// o_pt      out  point_x, point_y, point_z, saturated    valid / ready
// i_cfg_*   in   idx, data                               write enable, no wait
//
// One request per cycle while results are taken; requests go through the
// sine series, log and exp stages of each lane and the product stages.
// Reset clears the stage valid bits and loads the register defaults.
// A held result that is not taken freezes every stage; ready then drops.
`include "supertoroid_point_eval_macros.svh"

module supertoroid_point_eval #(
    parameter int ANGLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stpe_in_if.sink           i_ang,
    stpe_out_if.source        o_pt,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [23:0]       i_cfg_data
);

    localparam int NST = stpe_pkg::LANE_LAT + 6;
    localparam logic signed [33:0] MAXV = 34'sd2147483647;
    localparam logic signed [33:0] MINV = -34'sd2147483648;

    function automatic logic signed [44:0] f_mulq(input logic signed [33:0] a,
                                                  input logic signed [25:0] b);
        logic [33:0] ma;
        logic [25:0] mb;
        logic [59:0] pr;
        logic [43:0] r;
        ma = a[33] ? 34'(-a) : 34'(a);
        mb = b[25] ? 26'(-b) : 26'(b);
        pr = 60'(ma) * 60'(mb);
        r  = 44'((pr + 60'd32768) >> 16);
        return (a[33] ^ b[25]) ? -$signed(45'(r)) : $signed(45'(r));
    endfunction

    logic signed [23:0] r_ring, r_tube, r_sx, r_sy, r_sz;
    logic [15:0]        r_exp_ring, r_exp_tube;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring     <= 24'sd65536;
            r_tube     <= 24'sd32768;
            r_sx       <= 24'sd65536;
            r_sy       <= 24'sd65536;
            r_sz       <= 24'sd65536;
            r_exp_ring <= 16'd4096;
            r_exp_tube <= 16'd4096;
        end else if (i_cfg_we) begin
            case (stpe_pkg::t_cfg_idx'(i_cfg_idx))
                stpe_pkg::CFG_RING:     r_ring     <= i_cfg_data;
                stpe_pkg::CFG_TUBE:     r_tube     <= i_cfg_data;
                stpe_pkg::CFG_SCALE_X:  r_sx       <= i_cfg_data;
                stpe_pkg::CFG_SCALE_Y:  r_sy       <= i_cfg_data;
                stpe_pkg::CFG_SCALE_Z:  r_sz       <= i_cfg_data;
                stpe_pkg::CFG_EXP_RING: r_exp_ring <= i_cfg_data[15:0];
                stpe_pkg::CFG_EXP_TUBE: r_exp_tube <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic           w_en;
    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;

    assign w_en  = !r_vld[NST-1] || o_pt.ready;
    assign n_vld = {r_vld[NST-2:0], i_ang.valid};
    assign i_ang.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    logic [31:0] w_ph_u, w_ph_v;
    logic [60:0] w_pu, w_pv;
    logic [30:0] r_xu, r_xv;
    logic [1:0]  r_qu, r_qv;

    assign w_ph_u = 32'({16'd0, i_ang.angle_u} << (32 - ANGLE_BITS));
    assign w_ph_v = 32'({16'd0, i_ang.angle_v} << (32 - ANGLE_BITS));
    assign w_pu   = 61'(w_ph_u[29:0]) * 61'(stpe_pkg::HALF_PI_Q30);
    assign w_pv   = 61'(w_ph_v[29:0]) * 61'(stpe_pkg::HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xu <= w_pu[60:30];
            r_xv <= w_pv[60:30];
            r_qu <= w_ph_u[31:30];
            r_qv <= w_ph_v[31:30];
        end
    end

    stpe_pkg::t_lane_in w_in_su, w_in_cu, w_in_sv, w_in_cv;

    assign w_in_su = '{x: r_xu, odd: !r_qu[0], neg: r_qu[1]};
    assign w_in_cu = '{x: r_xu, odd: r_qu[0],  neg: r_qu[0] ^ r_qu[1]};
    assign w_in_sv = '{x: r_xv, odd: !r_qv[0], neg: r_qv[1]};
    assign w_in_cv = '{x: r_xv, odd: r_qv[0],  neg: r_qv[0] ^ r_qv[1]};

    logic signed [stpe_pkg::CS_W-1:0] w_cs_su, w_cs_cu, w_cs_sv, w_cs_cv;

    stpe_lane u_lane_su (.i_clk(i_clk), .i_en(w_en), .i_in(w_in_su),
                         .i_exp(r_exp_ring), .o_cs(w_cs_su));
    stpe_lane u_lane_cu (.i_clk(i_clk), .i_en(w_en), .i_in(w_in_cu),
                         .i_exp(r_exp_ring), .o_cs(w_cs_cu));
    stpe_lane u_lane_sv (.i_clk(i_clk), .i_en(w_en), .i_in(w_in_sv),
                         .i_exp(r_exp_tube), .o_cs(w_cs_sv));
    stpe_lane u_lane_cv (.i_clk(i_clk), .i_en(w_en), .i_in(w_in_cv),
                         .i_exp(r_exp_tube), .o_cs(w_cs_cv));

    logic signed [24:0] r_p1_tcv;
    logic signed [31:0] r_p1_szt, r_p2_szt;
    logic signed [stpe_pkg::CS_W-1:0] r_p1_su, r_p1_cu, r_p1_sv;
    logic signed [stpe_pkg::CS_W-1:0] r_p2_su, r_p2_cu, r_p2_sv;
    logic signed [stpe_pkg::CS_W-1:0] r_p3_su, r_p3_cu;
    logic signed [25:0] r_p2_w;
    logic signed [33:0] r_p3_sxw, r_p3_syw;
    logic signed [31:0] r_p3_pz, r_p4_pz;
    logic signed [33:0] r_p4_px, r_p4_py;
    logic [31:0]        r_px, r_py, r_pz;
    logic               r_sat;
    logic               w_sx_hi, w_sx_lo, w_sy_hi, w_sy_lo;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_tcv <= 25'(f_mulq(34'(r_tube), 26'(w_cs_cv)));
            r_p1_szt <= 32'(f_mulq(34'(r_sz), 26'(r_tube)));
            r_p1_su  <= w_cs_su;
            r_p1_cu  <= w_cs_cu;
            r_p1_sv  <= w_cs_sv;

            r_p2_w   <= 26'(r_ring) + 26'(r_p1_tcv);
            r_p2_szt <= r_p1_szt;
            r_p2_su  <= r_p1_su;
            r_p2_cu  <= r_p1_cu;
            r_p2_sv  <= r_p1_sv;

            r_p3_sxw <= 34'(f_mulq(34'(r_sx), r_p2_w));
            r_p3_syw <= 34'(f_mulq(34'(r_sy), r_p2_w));
            r_p3_pz  <= 32'(f_mulq(34'(r_p2_szt), 26'(r_p2_sv)));
            r_p3_su  <= r_p2_su;
            r_p3_cu  <= r_p2_cu;

            r_p4_px  <= 34'(f_mulq(r_p3_sxw, 26'(r_p3_su)));
            r_p4_py  <= 34'(f_mulq(r_p3_syw, 26'(r_p3_cu)));
            r_p4_pz  <= r_p3_pz;

            r_px  <= w_sx_hi ? MAXV[31:0] : (w_sx_lo ? MINV[31:0] : r_p4_px[31:0]);
            r_py  <= w_sy_hi ? MAXV[31:0] : (w_sy_lo ? MINV[31:0] : r_p4_py[31:0]);
            r_pz  <= r_p4_pz;
            r_sat <= w_sx_hi || w_sx_lo || w_sy_hi || w_sy_lo;
        end
    end

    assign w_sx_hi = r_p4_px > MAXV;
    assign w_sx_lo = r_p4_px < MINV;
    assign w_sy_hi = r_p4_py > MAXV;
    assign w_sy_lo = r_p4_py < MINV;

    assign o_pt.valid     = r_vld[NST-1];
    assign o_pt.point_x   = r_px;
    assign o_pt.point_y   = r_py;
    assign o_pt.point_z   = r_pz;
    assign o_pt.saturated = r_sat;

    `STPE_ASSERT_SAME(a_ready_only_held, !i_ang.ready, o_pt.valid && !o_pt.ready, "ready low without a held result")
    `STPE_ASSERT_NEXT(a_req_enters, i_ang.valid && i_ang.ready, r_vld[0], "accepted request missing from first stage")
    `STPE_ASSERT_SAME(a_sat_at_limit, o_pt.valid && o_pt.saturated, (o_pt.point_x == 32'h7FFFFFFF) || (o_pt.point_x == 32'h80000000) || (o_pt.point_y == 32'h7FFFFFFF) || (o_pt.point_y == 32'h80000000), "saturated flag without a clamped coordinate")
    `STPE_ASSERT_SAME(a_z_in_range, o_pt.valid, (o_pt.point_z != 32'h7FFFFFFF) && (o_pt.point_z != 32'h80000000), "z coordinate reached a clamp limit")

endmodule
